### rtl/core/mdc_pkg.sv
// Shared types, memory type codes and result queue sizing for the descriptor coalescer.
package mdc_pkg;

  localparam logic [3:0] EFI_LOADER_CODE        = 4'd1;
  localparam logic [3:0] EFI_LOADER_DATA        = 4'd2;
  localparam logic [3:0] EFI_BOOT_SERVICES_CODE = 4'd3;
  localparam logic [3:0] EFI_BOOT_SERVICES_DATA = 4'd4;
  localparam logic [3:0] EFI_CONVENTIONAL       = 4'd7;

  localparam int PAGE_SHIFT = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [3:0]  mem_type;
    logic [63:0] phys_start;
    logic [63:0] virt_start;
    logic [63:0] page_count;
    logic [63:0] attr_bits;
    logic        final_entry;
  } desc_in_t;

  typedef struct packed {
    logic [3:0]  out_type;
    logic [63:0] out_phys_start;
    logic [63:0] out_virt_start;
    logic [63:0] out_pages;
    logic [63:0] out_attr;
    logic        out_final;
  } desc_out_t;

  function automatic logic type_mergeable(input logic [3:0] t);
    type_mergeable = (t == EFI_LOADER_CODE) || (t == EFI_LOADER_DATA) ||
                     (t == EFI_BOOT_SERVICES_CODE) || (t == EFI_BOOT_SERVICES_DATA) ||
                     (t == EFI_CONVENTIONAL);
  endfunction

endpackage

### rtl/core/memory_descriptor_coalescer_top.sv
// Memory map descriptor coalescer: merges adjacent compatible descriptors into a result stream.
//
// Takes one memory map descriptor per cycle and holds one pending descriptor. A descriptor
// with equal attributes that starts where the pending one ends, with both types among loader
// code/data, boot services code/data and conventional, is folded into it as conventional
// memory; otherwise the pending one leaves and the new one is held. final_entry flushes the
// pending descriptor with out_final set. Each beat is decided in the cycle it is accepted
// (one 64-bit end-address compare against a precomputed end register) and its zero, one or two
// results go into a four-entry result queue read by out_valid/out_stall. in_stall is high
// while fewer than two queue entries are free, so with a free-running output the block takes
// one descriptor every cycle, and its results are registered in the queue and leave in order.
module memory_descriptor_coalescer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdc_pkg::desc_in_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mdc_pkg::desc_out_t  out_data
);

  logic                        pend_valid_r, pend_valid_nxt;
  logic [3:0]                  pend_type_r, pend_type_nxt;
  logic [63:0]                 pend_start_r, pend_start_nxt;
  logic [63:0]                 pend_virt_r, pend_virt_nxt;
  logic [63:0]                 pend_pages_r, pend_pages_nxt;
  logic [63:0]                 pend_attr_r, pend_attr_nxt;
  logic [63:0]                 pend_end_r, pend_end_nxt;

  mdc_pkg::desc_out_t          queue_r [mdc_pkg::QUEUE_DEPTH];
  logic [mdc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [mdc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [mdc_pkg::QCNT_W-1:0]  count_r, count_nxt;

  logic                        in_fire;
  logic                        out_fire;
  logic                        merge;
  logic                        emit_old;
  logic                        push_one;
  logic                        push_two;
  logic [1:0]                  push_n;
  logic [63:0]                 sum_pages;
  mdc_pkg::desc_out_t          old_desc;
  mdc_pkg::desc_out_t          fin_desc;
  mdc_pkg::desc_out_t          first_desc;
  logic [mdc_pkg::QPTR_W-1:0]  wr_ptr_inc;

  assign in_stall  = count_r > mdc_pkg::QCNT_W'(mdc_pkg::QUEUE_DEPTH - 2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = count_r != '0;
  assign out_fire  = out_valid && !out_stall;
  assign out_data  = queue_r[rd_ptr_r];

  always_comb begin
    merge = pend_valid_r && (in_data.attr_bits == pend_attr_r) &&
            (pend_end_r == in_data.phys_start) &&
            mdc_pkg::type_mergeable(in_data.mem_type) &&
            mdc_pkg::type_mergeable(pend_type_r);
    emit_old  = pend_valid_r && !merge;
    sum_pages = pend_pages_r + in_data.page_count;

    if (merge) begin
      pend_type_nxt  = mdc_pkg::EFI_CONVENTIONAL;
      pend_start_nxt = pend_start_r;
      pend_virt_nxt  = pend_virt_r;
      pend_pages_nxt = sum_pages;
      pend_attr_nxt  = pend_attr_r;
    end else begin
      pend_type_nxt  = in_data.mem_type;
      pend_start_nxt = in_data.phys_start;
      pend_virt_nxt  = in_data.virt_start;
      pend_pages_nxt = in_data.page_count;
      pend_attr_nxt  = in_data.attr_bits;
    end
    pend_end_nxt   = in_data.phys_start +
                     {in_data.page_count[63-mdc_pkg::PAGE_SHIFT:0],
                      {mdc_pkg::PAGE_SHIFT{1'b0}}};
    pend_valid_nxt = !in_data.final_entry;

    old_desc = '{out_type: pend_type_r, out_phys_start: pend_start_r,
                 out_virt_start: pend_virt_r, out_pages: pend_pages_r,
                 out_attr: pend_attr_r, out_final: 1'b0};
    fin_desc = '{out_type: pend_type_nxt, out_phys_start: pend_start_nxt,
                 out_virt_start: pend_virt_nxt, out_pages: pend_pages_nxt,
                 out_attr: pend_attr_nxt, out_final: 1'b1};
    first_desc = emit_old ? old_desc : fin_desc;

    push_one = in_fire && (emit_old || in_data.final_entry);
    push_two = in_fire && emit_old && in_data.final_entry;
    push_n   = {1'b0, push_one} + {1'b0, push_two};

    wr_ptr_inc = wr_ptr_r + mdc_pkg::QPTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + mdc_pkg::QPTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + mdc_pkg::QPTR_W'(out_fire);
    count_nxt  = count_r + mdc_pkg::QCNT_W'(push_n) - mdc_pkg::QCNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (in_fire) begin
        pend_valid_r <= pend_valid_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_type_r  <= pend_type_nxt;
      pend_start_r <= pend_start_nxt;
      pend_virt_r  <= pend_virt_nxt;
      pend_pages_r <= pend_pages_nxt;
      pend_attr_r  <= pend_attr_nxt;
      pend_end_r   <= pend_end_nxt;
    end
    for (int i = 0; i < mdc_pkg::QUEUE_DEPTH; i++) begin
      if (push_one && (wr_ptr_r == mdc_pkg::QPTR_W'(i))) begin
        queue_r[i] <= first_desc;
      end else if (push_two && (wr_ptr_inc == mdc_pkg::QPTR_W'(i))) begin
        queue_r[i] <= fin_desc;
      end
    end
  end

endmodule

### rtl/core/mdc_checker.sv
// Port-level checks for the descriptor coalescer, bound to its top level.
module mdc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mdc_pkg::desc_in_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mdc_pkg::desc_out_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_final_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.final_entry |=> out_valid)
    else $error("final input beat produced no result beat");

  a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result beat waiting");

endmodule

bind memory_descriptor_coalescer_top mdc_checker u_mdc_checker (.*);

### sim/tb.sv
// Self-checking testbench for the memory descriptor coalescer: directed table, then random maps.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdc_pkg::*;

  localparam logic [3:0]  EFI_RESERVED     = 4'd0;
  localparam logic [3:0]  EFI_RUNTIME_CODE = 4'd5;
  localparam logic [3:0]  EFI_UNUSABLE     = 4'd8;
  localparam logic [3:0]  EFI_TYPE_MAX     = 4'd15;
  localparam logic [63:0] ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          RANDOM_ITEMS     = 650;
  localparam int          WATCHDOG_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES    = 20;
  localparam int          NO_PIN           = -1;

  typedef struct {
    desc_in_t  d;
    int        pinned;
    desc_out_t p0;
    desc_out_t p1;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  desc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  desc_out_t out_data;

  desc_out_t expected_descs[$];
  dir_row_t  dir_rows[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;

  logic        held_valid = 1'b0;
  logic [3:0]  held_type = '0;
  logic [63:0] held_start = '0;
  logic [63:0] held_virt = '0;
  logic [63:0] held_pages = '0;
  logic [63:0] held_attr = '0;

  memory_descriptor_coalescer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial forever #2 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic joinable_type(input logic [3:0] t);
    return t == EFI_LOADER_CODE || t == EFI_LOADER_DATA || t == EFI_BOOT_SERVICES_CODE ||
           t == EFI_BOOT_SERVICES_DATA || t == EFI_CONVENTIONAL;
  endfunction

  function automatic desc_in_t in_desc(input logic [3:0] t, input logic [63:0] s,
                                       input logic [63:0] v, input logic [63:0] p,
                                       input logic [63:0] a, input logic f);
    desc_in_t d;
    d.mem_type    = t;
    d.phys_start  = s;
    d.virt_start  = v;
    d.page_count  = p;
    d.attr_bits   = a;
    d.final_entry = f;
    return d;
  endfunction

  function automatic desc_out_t out_desc(input logic [3:0] t, input logic [63:0] s,
                                         input logic [63:0] v, input logic [63:0] p,
                                         input logic [63:0] a, input logic f);
    desc_out_t r;
    r.out_type       = t;
    r.out_phys_start = s;
    r.out_virt_start = v;
    r.out_pages      = p;
    r.out_attr       = a;
    r.out_final      = f;
    return r;
  endfunction

  function automatic desc_out_t held_desc(input logic f);
    return out_desc(held_type, held_start, held_virt, held_pages, held_attr, f);
  endfunction

  function automatic int coalesce(input desc_in_t d, output desc_out_t r0,
                                  output desc_out_t r1);
    logic [63:0] run_end;
    logic        joined;
    int          n;
    n = 0;
    joined = 1'b0;
    r0 = '0;
    r1 = '0;
    if (held_valid) begin
      run_end = held_start + (held_pages << PAGE_SHIFT);
      if (d.attr_bits == held_attr && d.phys_start == run_end &&
          joinable_type(d.mem_type) && joinable_type(held_type)) begin
        held_type = EFI_CONVENTIONAL;
        held_pages = held_pages + d.page_count;
        joined = 1'b1;
      end else begin
        r0 = held_desc(1'b0);
        n = 1;
      end
    end
    if (!joined) begin
      held_valid = 1'b1;
      held_type  = d.mem_type;
      held_start = d.phys_start;
      held_virt  = d.virt_start;
      held_pages = d.page_count;
      held_attr  = d.attr_bits;
    end
    if (d.final_entry) begin
      if (n == 0) r0 = held_desc(1'b1);
      else r1 = held_desc(1'b1);
      n++;
      held_valid = 1'b0;
    end
    return n;
  endfunction

  function automatic desc_in_t next_map_desc(input logic last);
    desc_in_t d;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0: d.mem_type = EFI_LOADER_CODE;
        1: d.mem_type = EFI_LOADER_DATA;
        2: d.mem_type = EFI_BOOT_SERVICES_CODE;
        3: d.mem_type = EFI_BOOT_SERVICES_DATA;
        default: d.mem_type = EFI_CONVENTIONAL;
      endcase
    end else begin
      d.mem_type = 4'($urandom_range(0, 15));
    end
    d.virt_start = rand64();
    d.page_count = ($urandom_range(0, 15) == 0) ? rand64() : 64'($urandom_range(0, 64));
    if (held_valid && $urandom_range(0, 9) < 7) begin
      d.phys_start = held_start + (held_pages << PAGE_SHIFT);
      d.attr_bits = ($urandom_range(0, 9) == 0) ? rand64() : held_attr;
    end else begin
      d.phys_start = $urandom_range(0, 1) ? rand64() : {20'h0, $urandom, 12'h0};
      case ($urandom_range(0, 3))
        0: d.attr_bits = '0;
        1: d.attr_bits = 64'h8;
        2: d.attr_bits = 64'h8000_0000_0000_000F;
        default: d.attr_bits = rand64();
      endcase
    end
    d.final_entry = last;
    return d;
  endfunction

  task automatic add_row(input desc_in_t d, input int pinned, input desc_out_t p0,
                         input desc_out_t p1);
    dir_row_t row;
    row.d = d;
    row.pinned = pinned;
    row.p0 = p0;
    row.p1 = p1;
    dir_rows.push_back(row);
  endtask

  task automatic send_desc(input desc_in_t d, input int pinned, input desc_out_t p0,
                           input desc_out_t p1);
    desc_out_t r0;
    desc_out_t r1;
    int        n;
    int        gap;
    in_data <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n = coalesce(d, r0, r1);
    if (pinned != NO_PIN) begin
      n = pinned;
      r0 = p0;
      r1 = p1;
    end
    if (n > 0) expected_descs.push_back(r0);
    if (n > 1) expected_descs.push_back(r1);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_descs.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    desc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_descs.size() == 0) begin
        note_mismatch("beat with nothing pending, out_phys_start", '0, out_data.out_phys_start);
      end else begin
        want = expected_descs.pop_front();
        if (out_data.out_type != want.out_type)
          note_mismatch("out_type", 64'(want.out_type), 64'(out_data.out_type));
        if (out_data.out_phys_start != want.out_phys_start)
          note_mismatch("out_phys_start", want.out_phys_start, out_data.out_phys_start);
        if (out_data.out_virt_start != want.out_virt_start)
          note_mismatch("out_virt_start", want.out_virt_start, out_data.out_virt_start);
        if (out_data.out_pages != want.out_pages)
          note_mismatch("out_pages", want.out_pages, out_data.out_pages);
        if (out_data.out_attr != want.out_attr)
          note_mismatch("out_attr", want.out_attr, out_data.out_attr);
        if (out_data.out_final != want.out_final)
          note_mismatch("out_final", 64'(want.out_final), 64'(out_data.out_final));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    desc_in_t d;
    int       sent;
    int       map_len;

    add_row(in_desc(EFI_RESERVED, '0, '0, '0, '0, 1'b1), 1,
            out_desc(EFI_RESERVED, '0, '0, '0, '0, 1'b1), '0);
    add_row(in_desc(EFI_TYPE_MAX, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1), 1,
            out_desc(EFI_TYPE_MAX, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1), '0);
    add_row(in_desc(EFI_LOADER_CODE, 64'h1000, 64'hAAAA_0000, 64'd2, 64'h8, 1'b0), 0, '0, '0);
    add_row(in_desc(EFI_LOADER_DATA, 64'h3000, 64'h5555, 64'd3, 64'h8, 1'b0), 0, '0, '0);
    add_row(in_desc(EFI_BOOT_SERVICES_CODE, 64'h6000, 64'h7777, 64'd1, 64'h8, 1'b1), 1,
            out_desc(EFI_CONVENTIONAL, 64'h1000, 64'hAAAA_0000, 64'd6, 64'h8, 1'b1), '0);
    add_row(in_desc(EFI_BOOT_SERVICES_DATA, '0, 64'h10, 64'd1, 64'h1, 1'b0), 0, '0, '0);
    add_row(in_desc(EFI_BOOT_SERVICES_DATA, 64'h1000, 64'h20, 64'd1, 64'h2, 1'b1), 2,
            out_desc(EFI_BOOT_SERVICES_DATA, '0, 64'h10, 64'd1, 64'h1, 1'b0),
            out_desc(EFI_BOOT_SERVICES_DATA, 64'h1000, 64'h20, 64'd1, 64'h2, 1'b1));
    add_row(in_desc(EFI_CONVENTIONAL, 64'hFFFF_FFFF_FFFF_F000, 64'h1, 64'd1, 64'hF, 1'b0),
            0, '0, '0);
    add_row(in_desc(EFI_LOADER_CODE, '0, 64'h2, ALL_ONES, 64'hF, 1'b1), 1,
            out_desc(EFI_CONVENTIONAL, 64'hFFFF_FFFF_FFFF_F000, 64'h1, '0, 64'hF, 1'b1), '0);
    add_row(in_desc(EFI_RUNTIME_CODE, '0, '0, 64'd1, '0, 1'b0), 0, '0, '0);
    add_row(in_desc(EFI_CONVENTIONAL, 64'h1000, '0, 64'd1, '0, 1'b0), 1,
            out_desc(EFI_RUNTIME_CODE, '0, '0, 64'd1, '0, 1'b0), '0);
    add_row(in_desc(EFI_UNUSABLE, 64'h2000, '0, 64'd4, '0, 1'b0), 1,
            out_desc(EFI_CONVENTIONAL, 64'h1000, '0, 64'd1, '0, 1'b0), '0);
    add_row(in_desc(EFI_CONVENTIONAL, 64'h6000, '0, 64'd2, '0, 1'b1), NO_PIN, '0, '0);
    add_row(in_desc(EFI_LOADER_DATA, 64'h5000, 64'h9, 64'h0010_0000_0000_0002, 64'h3, 1'b0),
            NO_PIN, '0, '0);
    add_row(in_desc(EFI_LOADER_CODE, 64'h7000, 64'hA, 64'd5, 64'h3, 1'b0), NO_PIN, '0, '0);
    add_row(in_desc(EFI_CONVENTIONAL, 64'hC000, '0, '0, 64'h3, 1'b0), NO_PIN, '0, '0);
    add_row(in_desc(EFI_BOOT_SERVICES_CODE, 64'hC000, 64'hB, ALL_ONES, 64'h3, 1'b0),
            NO_PIN, '0, '0);
    add_row(in_desc(EFI_LOADER_DATA, 64'hC000, '0, 64'd1, 64'h3, 1'b1), NO_PIN, '0, '0);
    add_row(in_desc(EFI_CONVENTIONAL, 64'h10000, '0, 64'd1, ALL_ONES, 1'b0), NO_PIN, '0, '0);
    add_row(in_desc(EFI_CONVENTIONAL, 64'h12000, '0, 64'd1, ALL_ONES, 1'b1), NO_PIN, '0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_desc(dir_rows[i].d, dir_rows[i].pinned, dir_rows[i].p0, dir_rows[i].p1);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        d = in_desc(4'($urandom_range(0, 15)), rand64(), rand64(), rand64(), rand64(),
                    1'($urandom_range(0, 1)));
        send_desc(d, NO_PIN, '0, '0);
        sent++;
      end else begin
        map_len = $urandom_range(1, 12);
        for (int k = 0; k < map_len; k++) begin
          d = next_map_desc(k == map_len - 1);
          send_desc(d, NO_PIN, '0, '0);
          sent++;
        end
      end
      if ($urandom_range(0, 19) == 0) drain();
    end

    calm = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_descs.size() != 0)
      note_mismatch("descriptors still owed", 64'(expected_descs.size()), '0);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
